// ===== hdl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_SYNC(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== hdl/crsl_pkg.sv =====
package crsl_pkg;

  // request opcodes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_MEMBER = 2'd1;
  localparam logic [1:0] OP_NTH    = 2'd2;

  // configuration register addresses
  localparam logic [1:0] ADDR_RANGE_COUNT = 2'd0;

  localparam int CP_W = 31;

  // one stored range
  typedef struct packed {
    logic [CP_W-1:0] high;
    logic [CP_W-1:0] low;
  } range_t;

  // sequencer to walker control
  typedef struct packed {
    logic clear;
    logic step;
    logic first;
  } walk_ctl_t;

endpackage

// ===== hdl/character_range_set_lookup.sv =====
// character range set lookup: range table with membership and nth queries
// the walk reads n = min(range_count, MAX_RANGES) entries from the range memory,
//   one entry read per cycle through its single read port; a new request is taken only
//   once the walk for the previous one has ended with its result
// reset: synchronous; clears range_count and the sequencer, table contents stay undefined
// done marks each result for one cycle; the receiver cannot stall
`include "assert_macros.svh"

module character_range_set_lookup #(
  parameter int MAX_RANGES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [1:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // request
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 op,
  input  logic [5:0]                 entry_index,
  input  logic [crsl_pkg::CP_W-1:0]  range_low,
  input  logic [crsl_pkg::CP_W-1:0]  range_high,
  input  logic [crsl_pkg::CP_W-1:0]  code_point,
  input  logic [crsl_pkg::CP_W-1:0]  ordinal,
  // result
  output logic                       done,
  output logic                       hit,
  output logic                       nth_found,
  output logic [crsl_pkg::CP_W-1:0]  nth_value,
  output logic [31:0]                set_size,
  output logic                       table_valid
);

  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW = $clog2(MAX_RANGES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [6:0]               range_count;
  logic [1:0]               state;
  logic [1:0]               state_next;
  logic [CW-1:0]            active;
  logic [CW-1:0]            issue_cnt;
  logic                     rd_pend;
  logic                     rd_first;
  logic                     accept;
  logic                     rd_en;
  logic                     wr_en;
  crsl_pkg::range_t         wr_data;
  crsl_pkg::range_t         rd_data;
  crsl_pkg::walk_ctl_t      ctl;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == crsl_pkg::ADDR_RANGE_COUNT) ? {25'd0, range_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_count <= '0;
    end else if (psel && penable && pwrite && pready) begin
      range_count <= pwdata[6:0];
    end
  end

  // request handshake and table write
  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign wr_en   = accept && (op == crsl_pkg::OP_WRITE) && (32'(entry_index) < MAX_RANGES);
  assign wr_data = '{high: range_high, low: range_low};

  // walk issues one read per cycle
  assign rd_en = (state == ST_WALK) && (issue_cnt < active);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!rd_en && !rd_pend) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_cnt <= '0;
      rd_pend   <= 1'b0;
      rd_first  <= 1'b0;
      active    <= '0;
    end else begin
      state    <= state_next;
      rd_pend  <= rd_en;
      rd_first <= rd_en && (issue_cnt == '0);
      if (accept) begin
        issue_cnt <= '0;
        active    <= (32'(range_count) > MAX_RANGES) ? CW'(MAX_RANGES) : CW'(range_count);
      end else if (rd_en) begin
        issue_cnt <= issue_cnt + CW'(1);
      end
    end
  end

  assign done = (state == ST_DONE);

  assign ctl = '{clear: accept, step: rd_pend, first: rd_first};

  crsl_store #(
    .DEPTH (MAX_RANGES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(entry_index)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (issue_cnt[AW-1:0]),
    .rd_data (rd_data)
  );

  crsl_walk u_walk (
    .clk         (clk),
    .ctl         (ctl),
    .op          (op),
    .code_point  (code_point),
    .ordinal     (ordinal),
    .entry       (rd_data),
    .hit         (hit),
    .nth_found   (nth_found),
    .nth_value   (nth_value),
    .set_size    (set_size),
    .table_valid (table_valid)
  );

  // a result strobe frees the block for the next request
  `ASSERT_SYNC(a_done_frees, clk, rst, done |=> !busy)
  // an accepted request is never dropped before the walk
  `ASSERT_SYNC(a_accept_walks, clk, rst, accept |=> (state == ST_WALK))
  // reads never run past the active range count
  `ASSERT_SYNC(a_rd_bound, clk, rst, rd_en |=> (issue_cnt <= active))
  // reset leaves the sequencer idle
  `ASSERT_ALWAYS(a_rst_idle, clk, rst |=> (!busy && !done))

endmodule

// ===== hdl/crsl_store.sv =====
module crsl_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  crsl_pkg::range_t     wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output crsl_pkg::range_t     rd_data
);

  crsl_pkg::range_t mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/crsl_walk.sv =====
module crsl_walk (
  input  logic                       clk,
  input  crsl_pkg::walk_ctl_t        ctl,
  input  logic [1:0]                 op,
  input  logic [crsl_pkg::CP_W-1:0]  code_point,
  input  logic [crsl_pkg::CP_W-1:0]  ordinal,
  input  crsl_pkg::range_t           entry,
  output logic                       hit,
  output logic                       nth_found,
  output logic [crsl_pkg::CP_W-1:0]  nth_value,
  output logic [31:0]                set_size,
  output logic                       table_valid
);

  logic [1:0]                 op_q;
  logic [crsl_pkg::CP_W-1:0]  cp_q;
  logic [31:0]                rest;
  logic [crsl_pkg::CP_W-1:0]  prev_high;

  logic                       nonempty;
  logic [31:0]                span;
  logic [32:0]                sum;
  logic [31:0]                limit;
  logic                       in_range;
  logic                       take;

  // per-entry terms
  always_comb begin
    nonempty = entry.low <= entry.high;
    span     = {1'b0, entry.high} - {1'b0, entry.low} + 32'd1;
    sum      = {1'b0, set_size} + {1'b0, span};
    limit    = {1'b0, prev_high} + 32'd1;
    in_range = (entry.low <= cp_q) && (cp_q <= entry.high);
    take     = (op_q == crsl_pkg::OP_NTH) && !nth_found && nonempty;
  end

  // accumulate over the walk
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      op_q        <= op;
      cp_q        <= code_point;
      rest        <= {1'b0, ordinal};
      hit         <= 1'b0;
      nth_found   <= 1'b0;
      nth_value   <= '0;
      set_size    <= '0;
      table_valid <= 1'b1;
    end else if (ctl.step) begin
      prev_high <= entry.high;
      // saturating cardinality
      if (nonempty) begin
        set_size <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
      // well formed, sorted, non-adjacent
      if (!nonempty || (!ctl.first && ({1'b0, entry.low} <= limit))) begin
        table_valid <= 1'b0;
      end
      if (op_q == crsl_pkg::OP_MEMBER && in_range) begin
        hit <= 1'b1;
      end
      // ordinal walk
      if (take) begin
        if (rest < span) begin
          nth_found <= 1'b1;
          nth_value <= entry.low + rest[crsl_pkg::CP_W-1:0];
        end else begin
          rest <= rest - span;
        end
      end
    end
  end

endmodule

// ===== tb/character_range_set_lookup_test.sv =====
`timescale 1ns / 1ps

// one request as driven on the request ports
typedef struct {
  logic [1:0]  op;
  logic [5:0]  idx;
  logic [30:0] lo;
  logic [30:0] hi;
  logic [30:0] cp;
  logic [30:0] ord;
} lookup_request_t;

// one result as seen on the result ports
typedef struct {
  logic        hit;
  logic        found;
  logic [30:0] value;
  logic [31:0] size;
  logic        valid;
} lookup_result_t;

// tracks the range table and range_count, predicts each result in request order
class range_scoreboard;
  bit [30:0] low_tab [64];
  bit [30:0] high_tab [64];
  bit [6:0] range_count;
  lookup_result_t pending_q[$];
  int errors;
  int checked;
  int hits;
  int found;
  int saturated;

  function int active_ranges();
    return (range_count > 64) ? 64 : int'(range_count);
  endfunction

  // sum of range sizes, empty ranges add nothing, saturates at 32 bits
  function bit [31:0] members_total();
    longint unsigned total;
    total = 0;
    for (int k = 0; k < active_ranges(); k++) begin
      if (low_tab[k] <= high_tab[k])
        total += longint'(high_tab[k]) - longint'(low_tab[k]) + 1;
    end
    return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  // each range well formed and starting more than one past the previous end
  function bit ranges_ordered();
    longint unsigned limit;
    limit = 0;
    for (int k = 0; k < active_ranges(); k++) begin
      if (low_tab[k] > high_tab[k]) return 1'b0;
      if (k > 0 && longint'(low_tab[k]) <= limit) return 1'b0;
      limit = longint'(high_tab[k]) + 1;
    end
    return 1'b1;
  endfunction

  function bit covers(bit [30:0] cp);
    for (int k = 0; k < active_ranges(); k++) begin
      if (low_tab[k] <= cp && cp <= high_tab[k]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // walk ranges in table order, skipping empty ones
  function bit pick_member(input bit [30:0] ord, output bit [30:0] value);
    longint unsigned rest;
    longint unsigned span;
    rest = ord;
    value = '0;
    for (int k = 0; k < active_ranges(); k++) begin
      if (low_tab[k] > high_tab[k]) continue;
      span = longint'(high_tab[k]) - longint'(low_tab[k]) + 1;
      if (rest < span) begin
        value = low_tab[k] + rest[30:0];
        return 1'b1;
      end
      rest -= span;
    end
    return 1'b0;
  endfunction

  function int pending();
    return pending_q.size();
  endfunction

  function void note_request(lookup_request_t r);
    lookup_result_t want;
    bit [30:0] value;
    if (r.op == crsl_pkg::OP_WRITE) begin
      low_tab[r.idx] = r.lo;
      high_tab[r.idx] = r.hi;
    end
    want.hit = (r.op == crsl_pkg::OP_MEMBER) ? covers(r.cp) : 1'b0;
    want.found = 1'b0;
    want.value = '0;
    if (r.op == crsl_pkg::OP_NTH) begin
      want.found = pick_member(r.ord, value);
      want.value = value;
    end
    want.size = members_total();
    want.valid = ranges_ordered();
    hits += want.hit;
    found += want.found;
    if (want.size == 32'hFFFF_FFFF) saturated++;
    pending_q.push_back(want);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  task check_result(lookup_result_t got);
    lookup_result_t want;
    if (pending_q.size() == 0) begin
      report("result with no request outstanding");
    end else begin
      want = pending_q.pop_front();
      checked++;
      if (got.hit !== want.hit)
        report($sformatf("hit %b, expected %b", got.hit, want.hit));
      if (got.found !== want.found)
        report($sformatf("nth_found %b, expected %b", got.found, want.found));
      if (got.value !== want.value)
        report($sformatf("nth_value %h, expected %h", got.value, want.value));
      if (got.size !== want.size)
        report($sformatf("set_size %h, expected %h", got.size, want.size));
      if (got.valid !== want.valid)
        report($sformatf("table_valid %b, expected %b", got.valid, want.valid));
    end
  endtask
endclass

module character_range_set_lookup_test;

  localparam logic [1:0] OP_STATUS = 2'd3;
  localparam int TARGET_REQUESTS = 1850;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [1:0]  op;
  logic [5:0]  entry_index;
  logic [30:0] range_low;
  logic [30:0] range_high;
  logic [30:0] code_point;
  logic [30:0] ordinal;
  logic        done;
  logic        hit;
  logic        nth_found;
  logic [30:0] nth_value;
  logic [31:0] set_size;
  logic        table_valid;

  range_scoreboard sb;
  int requests_sent;
  int settings_used;
  int gap_max;

  character_range_set_lookup dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .op(op), .entry_index(entry_index),
    .range_low(range_low), .range_high(range_high),
    .code_point(code_point), .ordinal(ordinal),
    .done(done), .hit(hit), .nth_found(nth_found), .nth_value(nth_value),
    .set_size(set_size), .table_valid(table_valid)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("character_range_set_lookup regression: fail");
    $finish;
  end

  // results are sampled at the edge that ends their strobe cycle
  always @(posedge clk) begin
    lookup_result_t got;
    if (!rst && done) begin
      got.hit = hit;
      got.found = nth_found;
      got.value = nth_value;
      got.size = set_size;
      got.valid = table_valid;
      sb.check_result(got);
    end
  end

  function automatic lookup_request_t make_request(logic [1:0] kind);
    lookup_request_t r;
    r.op = kind;
    r.idx = 6'($urandom_range(0, 63));
    r.lo = 31'($urandom());
    r.hi = 31'($urandom());
    r.cp = 31'($urandom());
    r.ord = 31'($urandom());
    return r;
  endfunction

  // random hold-off, then hold start until the block takes the request
  task automatic send_request(input lookup_request_t r);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= r.op;
    entry_index <= r.idx;
    range_low <= r.lo;
    range_high <= r.hi;
    code_point <= r.cp;
    ordinal <= r.ord;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    requests_sent++;
  endtask

  task automatic do_write(input int idx, input logic [30:0] lo, input logic [30:0] hi);
    lookup_request_t r;
    r = make_request(crsl_pkg::OP_WRITE);
    r.idx = 6'(idx);
    r.lo = lo;
    r.hi = hi;
    send_request(r);
  endtask

  task automatic do_member(input logic [30:0] cp);
    lookup_request_t r;
    r = make_request(crsl_pkg::OP_MEMBER);
    r.cp = cp;
    send_request(r);
  endtask

  task automatic do_nth(input logic [30:0] ord);
    lookup_request_t r;
    r = make_request(crsl_pkg::OP_NTH);
    r.ord = ord;
    send_request(r);
  endtask

  // register write only once the block has drained
  task automatic write_range_count(input bit [6:0] value);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= crsl_pkg::ADDR_RANGE_COUNT;
    pwdata <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.range_count = value;
    settings_used++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // load entries 0..entries-1, sorted and separated or deliberately broken
  task automatic load_table(input bit well_formed, input int entries);
    longint unsigned cursor;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned prev_lo;
    longint unsigned prev_hi;
    bit wide;
    bit to_top;
    wide = 1'($urandom_range(0, 1));
    to_top = ($urandom_range(0, 3) == 0);
    cursor = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, wide ? (1 << 28) : 1000);
    prev_lo = 0;
    prev_hi = 0;
    for (int k = 0; k < entries; k++) begin
      if (well_formed) begin
        if (k > 0) cursor += wide ? $urandom_range(2, 1 << 23) : $urandom_range(2, 20);
        lo = cursor;
        hi = lo + (wide ? $urandom_range(0, 1 << 23) : $urandom_range(0, 30));
        if (to_top && k == entries - 1) hi = 31'h7FFF_FFFF;
        cursor = hi;
      end else begin
        case ($urandom_range(0, 4))
          0: begin
            lo = $urandom() & 32'h7FFF_FFFF;
            hi = $urandom() & 32'h7FFF_FFFF;
          end
          1: begin
            lo = $urandom() & 32'h7FFF_FFFF;
            hi = lo;
          end
          // overlaps the previous range
          2: begin
            lo = (prev_lo + $urandom_range(0, 8)) & 32'h7FFF_FFFF;
            hi = (lo + $urandom_range(0, 40)) & 32'h7FFF_FFFF;
          end
          // starts right after the previous end
          3: begin
            lo = (prev_hi + 1) & 32'h7FFF_FFFF;
            hi = (lo + $urandom_range(0, 40)) & 32'h7FFF_FFFF;
          end
          // empty range
          default: begin
            hi = $urandom_range(0, 1 << 20);
            lo = hi + $urandom_range(1, 50);
          end
        endcase
      end
      prev_lo = lo;
      prev_hi = hi;
      do_write(k, lo[30:0], hi[30:0]);
    end
  endtask

  // queries aimed at range edges and around the cardinality, plus random writes, status requests and noise
  task automatic query_burst(input int len);
    int sel;
    int k;
    int n;
    bit [30:0] cp;
    bit [31:0] total;
    bit [31:0] ord;
    lookup_request_t r;
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(0, 99);
      n = sb.active_ranges();
      if (sel < 42) begin
        cp = 31'($urandom());
        if (n > 0) begin
          k = $urandom_range(0, n - 1);
          case ($urandom_range(0, 5))
            0: cp = sb.low_tab[k] - 31'd1;
            1: cp = sb.low_tab[k];
            2: cp = sb.high_tab[k];
            3: cp = sb.high_tab[k] + 31'd1;
            4: if (sb.low_tab[k] <= sb.high_tab[k])
                 cp = 31'(sb.low_tab[k] +
                          $urandom_range(0, sb.high_tab[k] - sb.low_tab[k]));
            default: ;
          endcase
        end
        do_member(cp);
      end else if (sel < 82) begin
        total = sb.members_total();
        ord = $urandom();
        case ($urandom_range(0, 5))
          0: ord = 0;
          1: ord = total - 1;
          2: ord = total;
          3: ord = total + 1;
          4: if (total > 0) ord = $urandom_range(0, total - 1);
          default: ;
        endcase
        do_nth(ord[30:0]);
      end else if (sel < 92) begin
        r = make_request(crsl_pkg::OP_WRITE);
        if ($urandom_range(0, 1) == 0) r.hi = 31'(r.lo + $urandom_range(0, 100));
        send_request(r);
      end else if (sel < 97) begin
        send_request(make_request(OP_STATUS));
      end else begin
        do_member(31'($urandom()));
      end
    end
  endtask

  initial begin
    bit [30:0] total;
    int count_plan [8];
    int cnt;
    int phase;
    int waited;
    sb = new();
    count_plan = '{64, 127, 1, 65, 0, 2, 64, 33};
    requests_sent = 0;
    settings_used = 0;
    gap_max = 10;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    start <= 1'b0;
    op <= '0;
    entry_index <= '0;
    range_low <= '0;
    range_high <= '0;
    code_point <= '0;
    ordinal <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every entry while the set is still empty
    write_range_count(7'd0);
    load_table(1'b1, 64);

    // directed: extremes and the special cases on a three range set
    write_range_count(7'd3);
    do_write(0, 31'd0, 31'd0);
    do_write(1, 31'd2, 31'd10);
    do_write(2, 31'h7FFF_FFF0, 31'h7FFF_FFFF);
    do_member(31'd0);
    do_member(31'd1);
    do_member(31'd10);
    do_member(31'd11);
    do_member(31'h7FFF_FFFF);
    total = 31'(sb.members_total());
    do_nth(31'd0);
    do_nth(31'd1);
    do_nth(31'd9);
    do_nth(31'd10);
    do_nth(total - 31'd1);
    do_nth(total);
    do_nth(31'h7FFF_FFFF);
    send_request(make_request(OP_STATUS));
    // empty range in the middle
    do_write(1, 31'd10, 31'd2);
    do_member(31'd5);
    do_nth(31'd1);
    // range adjacent to its neighbor
    do_write(1, 31'd1, 31'd10);
    do_member(31'd1);
    // three full overlapping ranges saturate the cardinality
    do_write(0, 31'd0, 31'h7FFF_FFFF);
    do_write(1, 31'd0, 31'h7FFF_FFFF);
    do_write(2, 31'd0, 31'h7FFF_FFFF);
    do_nth(31'h7FFF_FFFF);

    // random phases, each with its own range_count and table
    phase = 0;
    while (requests_sent < TARGET_REQUESTS) begin
      cnt = (phase < 8) ? count_plan[phase] : $urandom_range(0, 127);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      write_range_count(cnt[6:0]);
      load_table($urandom_range(0, 4) != 0, (cnt == 0) ? 4 : ((cnt > 64) ? 64 : cnt));
      query_burst($urandom_range(30, 70));
      phase++;
    end

    // drain, then allow the longest walk to finish
    start <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0) begin
      $display("character_range_set_lookup regression: fail");
      $finish;
    end else begin
      repeat (80) @(posedge clk);
      $display("%0d requests over %0d range_count settings, %0d results checked",
               requests_sent, settings_used, sb.checked);
      $display("membership hits %0d, nth members found %0d, saturated set sizes %0d",
               sb.hits, sb.found, sb.saturated);
      if (sb.errors == 0)
        $display("character_range_set_lookup regression: pass");
      else
        $display("character_range_set_lookup regression: fail");
      $finish;
    end
  end

endmodule
